FILE: hw/rtl/sc2a_pkg.sv
// Package for the scancode-set-1 to ASCII translator.
// Holds the event codes, the flag layout, scancode constants and the key ROMs.
// No dependencies.
package sc2a_pkg;

	// Result kinds
	typedef enum logic [1:0] {
		KIND_CHAR = 2'd0,
		KIND_EOF  = 2'd1,
		KIND_INT  = 2'd2
	} event_kind_t;

	// Modifier flag bits
	localparam int unsigned FLAG_SHIFT = 0;
	localparam int unsigned FLAG_CTRL  = 1;
	localparam int unsigned FLAG_ALT   = 2;
	localparam int unsigned FLAG_EXT   = 3;

	typedef logic [3:0] mod_flags_t;

	// Special scancodes
	localparam logic [7:0] SC_PREFIX = 8'hE0;
	localparam logic [7:0] SC_CAPS   = 8'h3A;
	localparam logic [6:0] KEY_LSHIFT = 7'h2A;
	localparam logic [6:0] KEY_RSHIFT = 7'h36;
	localparam logic [6:0] KEY_CTRL   = 7'h1D;
	localparam logic [6:0] KEY_ALT    = 7'h38;

	localparam logic [6:0] ASCII_LOWER_C = 7'h63;
	localparam logic [6:0] ASCII_LOWER_D = 7'h64;

	// Decoder results for one byte
	typedef struct packed {
		logic        emit;
		logic [6:0]  char_code;
		event_kind_t kind;
		mod_flags_t  flags_nxt;
		logic        caps_nxt;
	} dec_out_t;

	// Unshifted key ROM
	function automatic logic [6:0] plain_rom(input logic [6:0] key);
		logic [6:0] ch;
		ch = 7'h00;
		case (key)
			7'h01: ch = 7'h1B; 7'h02: ch = 7'h31; 7'h03: ch = 7'h32; 7'h04: ch = 7'h33;
			7'h05: ch = 7'h34; 7'h06: ch = 7'h35; 7'h07: ch = 7'h36; 7'h08: ch = 7'h37;
			7'h09: ch = 7'h38; 7'h0A: ch = 7'h39; 7'h0B: ch = 7'h30; 7'h0C: ch = 7'h2D;
			7'h0D: ch = 7'h3D; 7'h0E: ch = 7'h08; 7'h0F: ch = 7'h09;
			7'h10: ch = 7'h71; 7'h11: ch = 7'h77; 7'h12: ch = 7'h65; 7'h13: ch = 7'h72;
			7'h14: ch = 7'h74; 7'h15: ch = 7'h79; 7'h16: ch = 7'h75; 7'h17: ch = 7'h69;
			7'h18: ch = 7'h6F; 7'h19: ch = 7'h70; 7'h1A: ch = 7'h5B; 7'h1B: ch = 7'h5D;
			7'h1C: ch = 7'h0A; 7'h1E: ch = 7'h61; 7'h1F: ch = 7'h73;
			7'h20: ch = 7'h64; 7'h21: ch = 7'h66; 7'h22: ch = 7'h67; 7'h23: ch = 7'h68;
			7'h24: ch = 7'h6A; 7'h25: ch = 7'h6B; 7'h26: ch = 7'h6C; 7'h27: ch = 7'h3B;
			7'h28: ch = 7'h27; 7'h29: ch = 7'h60; 7'h2B: ch = 7'h5C; 7'h2C: ch = 7'h7A;
			7'h2D: ch = 7'h78; 7'h2E: ch = 7'h63; 7'h2F: ch = 7'h76;
			7'h30: ch = 7'h62; 7'h31: ch = 7'h6E; 7'h32: ch = 7'h6D; 7'h33: ch = 7'h2C;
			7'h34: ch = 7'h2E; 7'h35: ch = 7'h2F; 7'h37: ch = 7'h2A; 7'h39: ch = 7'h20;
			7'h4A: ch = 7'h2D; 7'h4E: ch = 7'h2B;
			default: ch = 7'h00;
		endcase
		return ch;
	endfunction

	// Shifted key ROM
	function automatic logic [6:0] shifted_rom(input logic [6:0] key);
		logic [6:0] ch;
		ch = 7'h00;
		case (key)
			7'h01: ch = 7'h1B; 7'h02: ch = 7'h21; 7'h03: ch = 7'h40; 7'h04: ch = 7'h23;
			7'h05: ch = 7'h24; 7'h06: ch = 7'h25; 7'h07: ch = 7'h5E; 7'h08: ch = 7'h26;
			7'h09: ch = 7'h2A; 7'h0A: ch = 7'h28; 7'h0B: ch = 7'h29; 7'h0C: ch = 7'h5F;
			7'h0D: ch = 7'h2B; 7'h0E: ch = 7'h08; 7'h0F: ch = 7'h09;
			7'h10: ch = 7'h51; 7'h11: ch = 7'h57; 7'h12: ch = 7'h45; 7'h13: ch = 7'h52;
			7'h14: ch = 7'h54; 7'h15: ch = 7'h59; 7'h16: ch = 7'h55; 7'h17: ch = 7'h49;
			7'h18: ch = 7'h4F; 7'h19: ch = 7'h50; 7'h1A: ch = 7'h7B; 7'h1B: ch = 7'h7D;
			7'h1C: ch = 7'h0A; 7'h1E: ch = 7'h41; 7'h1F: ch = 7'h53;
			7'h20: ch = 7'h44; 7'h21: ch = 7'h46; 7'h22: ch = 7'h47; 7'h23: ch = 7'h48;
			7'h24: ch = 7'h4A; 7'h25: ch = 7'h4B; 7'h26: ch = 7'h4C; 7'h27: ch = 7'h3A;
			7'h28: ch = 7'h22; 7'h29: ch = 7'h7E; 7'h2B: ch = 7'h7C; 7'h2C: ch = 7'h5A;
			7'h2D: ch = 7'h58; 7'h2E: ch = 7'h43; 7'h2F: ch = 7'h56;
			7'h30: ch = 7'h42; 7'h31: ch = 7'h4E; 7'h32: ch = 7'h4D; 7'h33: ch = 7'h3C;
			7'h34: ch = 7'h3E; 7'h35: ch = 7'h3F; 7'h37: ch = 7'h2A; 7'h39: ch = 7'h20;
			7'h4A: ch = 7'h2D; 7'h4E: ch = 7'h2B;
			default: ch = 7'h00;
		endcase
		return ch;
	endfunction

endpackage

FILE: hw/rtl/scancode_to_ascii_translator.sv
// Top level of the scancode-set-1 to ASCII translator.
// Depends on sc2a_pkg and sc2a_decode.
//
// Usage:
//   Input channel in_valid/in_ready carries one raw keyboard byte (scancode)
//   per item. Output channel out_valid/out_ready carries one result item
//   (char_code, event_kind) for each byte that produces a character or a
//   ctrl-c / ctrl-d event; prefix bytes, modifier codes, caps lock, releases
//   and keys without a character produce nothing.
//   Path: the byte sits in the input register, then the decode loads the
//   result register from it when the result register is free or drains.
//   Throughput: one byte per cycle while the result register is free or drains;
//   the decode is one ROM lookup and a few compares between the input register
//   and the result register, and the modifier and caps state update in that same cycle.
//   Reset clears the modifier flags, caps lock and both valid bits.
//   When the receiver stalls with a result pending, the input register holds
//   its byte and in_ready drops once it is full; bytes that produce no
//   result still drain as long as the result register is free.
module scancode_to_ascii_translator (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] scancode,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [6:0] char_code,
	output logic [1:0] event_kind
);
	import sc2a_pkg::*;

	logic        valid_s1;
	logic [7:0]  scancode_s1;
	mod_flags_t  flags_q;
	logic        caps_q;
	logic        out_valid_q;
	logic [6:0]  char_code_q;
	event_kind_t kind_q;
	logic        advance;
	dec_out_t    dec;

	// Stage 1 moves forward whenever the result register is free or drains
	assign advance  = !out_valid_q || out_ready;
	assign in_ready = !valid_s1 || advance;

	sc2a_decode u_decode (
		.scancode (scancode_s1),
		.flags    (flags_q),
		.caps     (caps_q),
		.dec      (dec)
	);

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			scancode_s1 <= scancode;
		end
	end

	// Keyboard state, updated as each byte leaves stage 1
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flags_q <= '0;
			caps_q  <= 1'b0;
		end else if (valid_s1 && advance) begin
			flags_q <= dec.flags_nxt;
			caps_q  <= dec.caps_nxt;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1 && dec.emit;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1 && dec.emit) begin
			char_code_q <= dec.char_code;
			kind_q      <= dec.kind;
		end
	end

	assign out_valid  = out_valid_q;
	assign char_code  = char_code_q;
	assign event_kind = kind_q;

endmodule

FILE: hw/rtl/sc2a_decode.sv
// Single-byte decoder: flag update, ROM lookup, ctrl events and caps-lock case swap.
// Depends on sc2a_pkg.
module sc2a_decode (
	input  logic [7:0]           scancode,
	input  sc2a_pkg::mod_flags_t flags,
	input  logic                 caps,
	output sc2a_pkg::dec_out_t   dec
);
	import sc2a_pkg::*;

	logic       release_b;
	logic [6:0] key;
	mod_flags_t mod_bit;
	logic [6:0] ch_raw;
	logic       is_letter;

	assign release_b = scancode[7];
	assign key       = scancode[6:0];

	// Which modifier this key drives; shift keys only count without the prefix
	always_comb begin
		mod_bit = '0;
		if (key == KEY_CTRL) begin
			mod_bit[FLAG_CTRL] = 1'b1;
		end else if (key == KEY_ALT) begin
			mod_bit[FLAG_ALT] = 1'b1;
		end else if (!flags[FLAG_EXT] && (key == KEY_LSHIFT || key == KEY_RSHIFT)) begin
			mod_bit[FLAG_SHIFT] = 1'b1;
		end
	end

	assign ch_raw    = flags[FLAG_SHIFT] ? shifted_rom(key) : plain_rom(key);
	assign is_letter = (ch_raw >= 7'h61 && ch_raw <= 7'h7A) ||
	                   (ch_raw >= 7'h41 && ch_raw <= 7'h5A);

	// Main decode, order of checks follows the key priority
	always_comb begin
		dec.emit      = 1'b0;
		dec.char_code = ch_raw;
		dec.kind      = KIND_CHAR;
		dec.flags_nxt = flags;
		dec.caps_nxt  = caps;
		priority if (scancode == SC_PREFIX) begin
			dec.flags_nxt[FLAG_EXT] = 1'b1;
		end else if (scancode == SC_CAPS) begin
			dec.caps_nxt = !caps;
		end else if (mod_bit != '0) begin
			dec.flags_nxt = release_b ? (flags & ~mod_bit) : (flags | mod_bit);
		end else if (release_b) begin
			dec.flags_nxt[FLAG_EXT] = 1'b0;
		end else begin
			if (flags[FLAG_CTRL] && ch_raw == ASCII_LOWER_D) begin
				dec.kind      = KIND_EOF;
				dec.char_code = '0;
			end else if (flags[FLAG_CTRL] && ch_raw == ASCII_LOWER_C) begin
				dec.kind      = KIND_INT;
				dec.char_code = '0;
			end else if (caps && is_letter) begin
				dec.char_code[5] = !ch_raw[5];
			end
			dec.emit = (dec.kind != KIND_CHAR) || (ch_raw != '0);
		end
	end

endmodule

FILE: hw/rtl/sc2a_checker.sv
// Port-level checks for the scancode-set-1 to ASCII translator.
// Depends on sc2a_pkg; bound to scancode_to_ascii_translator below.
module sc2a_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_ready,
	input logic [6:0] char_code,
	input logic [1:0] event_kind
);
	import sc2a_pkg::*;

	// Events carry no character
	a_event_no_char: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (event_kind == KIND_EOF || event_kind == KIND_INT) |-> char_code == '0)
		else $error("event item carries a character");

	// Character items are never null
	a_char_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && event_kind == KIND_CHAR |-> char_code != '0)
		else $error("null character item");

	// Only defined kinds appear
	a_kind_defined: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (event_kind == KIND_CHAR || event_kind == KIND_EOF ||
		               event_kind == KIND_INT))
		else $error("undefined event kind");

	// A stalled item holds
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(char_code) && $stable(event_kind))
		else $error("stalled item changed");

endmodule

bind scancode_to_ascii_translator sc2a_checker u_sc2a_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.out_valid  (out_valid),
	.out_ready  (out_ready),
	.char_code  (char_code),
	.event_kind (event_kind)
);

FILE: tb/sv/tb_scancode_to_ascii_translator.sv
// Self-checking testbench for scancode_to_ascii_translator: directed and random
// keyboard bytes, a built-in key decoder as predictor, random idling on both sides.
// Depends on sc2a_pkg and the translator RTL.
module tb_scancode_to_ascii_translator;
	timeunit 1ns;
	timeprecision 1ps;

	import sc2a_pkg::*;

	localparam int unsigned TARGET_ITEMS = 1850;
	localparam int unsigned QUIET_LIMIT  = 1000;
	localparam int unsigned DRAIN_CYCLES = 8;
	localparam logic [7:0]  RELEASE_BIT  = 8'h80;
	localparam logic [6:0]  CASE_BIT     = 7'h20;
	localparam int unsigned KEY_ROWS     = 80;

	// Key layout, unshifted and shifted; keys past the table have no character
	localparam logic [6:0] UNSHIFTED_CHARS [0:KEY_ROWS-1] = '{
		7'h00, 7'h1B, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36,
		7'h37, 7'h38, 7'h39, 7'h30, 7'h2D, 7'h3D, 7'h08, 7'h09,
		7'h71, 7'h77, 7'h65, 7'h72, 7'h74, 7'h79, 7'h75, 7'h69,
		7'h6F, 7'h70, 7'h5B, 7'h5D, 7'h0A, 7'h00, 7'h61, 7'h73,
		7'h64, 7'h66, 7'h67, 7'h68, 7'h6A, 7'h6B, 7'h6C, 7'h3B,
		7'h27, 7'h60, 7'h00, 7'h5C, 7'h7A, 7'h78, 7'h63, 7'h76,
		7'h62, 7'h6E, 7'h6D, 7'h2C, 7'h2E, 7'h2F, 7'h00, 7'h2A,
		7'h00, 7'h20, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00,
		7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00,
		7'h00, 7'h00, 7'h2D, 7'h00, 7'h00, 7'h00, 7'h2B, 7'h00
	};
	localparam logic [6:0] SHIFTED_CHARS [0:KEY_ROWS-1] = '{
		7'h00, 7'h1B, 7'h21, 7'h40, 7'h23, 7'h24, 7'h25, 7'h5E,
		7'h26, 7'h2A, 7'h28, 7'h29, 7'h5F, 7'h2B, 7'h08, 7'h09,
		7'h51, 7'h57, 7'h45, 7'h52, 7'h54, 7'h59, 7'h55, 7'h49,
		7'h4F, 7'h50, 7'h7B, 7'h7D, 7'h0A, 7'h00, 7'h41, 7'h53,
		7'h44, 7'h46, 7'h47, 7'h48, 7'h4A, 7'h4B, 7'h4C, 7'h3A,
		7'h22, 7'h7E, 7'h00, 7'h7C, 7'h5A, 7'h58, 7'h43, 7'h56,
		7'h42, 7'h4E, 7'h4D, 7'h3C, 7'h3E, 7'h3F, 7'h00, 7'h2A,
		7'h00, 7'h20, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00,
		7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00,
		7'h00, 7'h00, 7'h2D, 7'h00, 7'h00, 7'h00, 7'h2B, 7'h00
	};

	typedef struct {
		logic [6:0]  ch;
		event_kind_t kind;
	} key_result_t;

	// Keyboard state tracker and queue of expected key results
	class keyboard_scoreboard;
		mod_flags_t  flags;
		bit          caps_on;
		key_result_t expected_q[$];
		int unsigned mismatches;
		int unsigned results_seen;

		function new();
			flags        = '0;
			caps_on      = 1'b0;
			mismatches   = 0;
			results_seen = 0;
		endfunction

		function void note_failure(string msg);
			if (mismatches < 10) begin
				$display("[%0t] %s", $realtime, msg);
			end
			mismatches++;
		endfunction

		// Apply one accepted byte to the tracked state, queue any result
		function void note_scancode(logic [7:0] code);
			logic [6:0]  key;
			logic [6:0]  ch;
			bit          rel;
			int          mod_idx;
			event_kind_t kind;
			key_result_t res;
			key     = code[6:0];
			rel     = code[7];
			mod_idx = -1;
			if (key == KEY_CTRL) begin
				mod_idx = FLAG_CTRL;
			end else if (key == KEY_ALT) begin
				mod_idx = FLAG_ALT;
			end else if (!flags[FLAG_EXT] && (key == KEY_LSHIFT || key == KEY_RSHIFT)) begin
				mod_idx = FLAG_SHIFT;
			end

			if (code == SC_PREFIX) begin
				flags[FLAG_EXT] = 1'b1;
			end else if (code == SC_CAPS) begin
				caps_on = !caps_on;
			end else if (mod_idx >= 0) begin
				flags[mod_idx] = !rel;
			end else if (rel) begin
				flags[FLAG_EXT] = 1'b0;
			end else begin
				ch = 7'h00;
				if (key < KEY_ROWS) begin
					ch = flags[FLAG_SHIFT] ? SHIFTED_CHARS[key] : UNSHIFTED_CHARS[key];
				end
				kind = KIND_CHAR;
				// ctrl turns lowercase d and c into events
				if (flags[FLAG_CTRL] && ch == ASCII_LOWER_D) begin
					kind = KIND_EOF;
					ch   = 7'h00;
				end else if (flags[FLAG_CTRL] && ch == ASCII_LOWER_C) begin
					kind = KIND_INT;
					ch   = 7'h00;
				end
				// caps lock flips letter case
				if (caps_on && kind == KIND_CHAR) begin
					if (ch >= 7'h61 && ch <= 7'h7A) begin
						ch = ch - CASE_BIT;
					end else if (ch >= 7'h41 && ch <= 7'h5A) begin
						ch = ch + CASE_BIT;
					end
				end
				if (kind != KIND_CHAR || ch != 7'h00) begin
					res.ch   = ch;
					res.kind = kind;
					expected_q.push_back(res);
				end
			end
		endfunction

		// Compare one accepted result with the oldest expectation
		function void check_result(logic [6:0] ch, logic [1:0] kind);
			key_result_t exp_res;
			results_seen++;
			if (expected_q.size() == 0) begin
				note_failure($sformatf("unexpected result char_code=%02h event_kind=%0d",
					ch, kind));
				return;
			end
			exp_res = expected_q.pop_front();
			if (ch !== exp_res.ch) begin
				note_failure($sformatf("result %0d: char_code expected %02h got %02h",
					results_seen, exp_res.ch, ch));
			end
			if (kind !== exp_res.kind) begin
				note_failure($sformatf("result %0d: event_kind expected %0d got %0d",
					results_seen, exp_res.kind, kind));
			end
		endfunction

		function int unsigned pending();
			return expected_q.size();
		endfunction
	endclass

	logic       clk;
	logic       arst_n    = 1'b0;
	logic       in_valid  = 1'b0;
	logic       in_ready;
	logic [7:0] scancode  = 8'h00;
	logic       out_valid;
	logic       out_ready = 1'b0;
	logic [6:0] char_code;
	logic [1:0] event_kind;

	keyboard_scoreboard sb = new();

	int unsigned accepted_items = 0;
	int unsigned quiet_cycles   = 0;
	int unsigned burst_left     = 0;

	scancode_to_ascii_translator u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.scancode  (scancode),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.char_code (char_code),
		.event_kind(event_kind)
	);

	// Clock
	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Handshake monitor: predict on accepted bytes, check accepted results
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready) begin
				sb.note_scancode(scancode);
				accepted_items++;
			end
			if (out_valid && out_ready) begin
				sb.check_result(char_code, event_kind);
			end
			if ((in_valid && in_ready) || (out_valid && out_ready)) begin
				quiet_cycles <= 0;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	// Receiver: switches between always ready, random ready and stall runs
	int unsigned rx_mode  = 0;
	int unsigned rx_left  = 0;
	int unsigned rx_stall = 0;
	always @(posedge clk) begin
		if (rx_left == 0) begin
			rx_mode <= $urandom_range(0, 2);
			rx_left <= $urandom_range(20, 200);
		end else begin
			rx_left <= rx_left - 1;
		end
		case (rx_mode)
			0: begin
				out_ready <= 1'b1;
			end
			1: begin
				out_ready <= ($urandom_range(0, 3) != 0);
			end
			default: begin
				if (rx_stall != 0) begin
					out_ready <= 1'b0;
					rx_stall  <= rx_stall - 1;
				end else begin
					out_ready <= 1'b1;
					rx_stall  <= ($urandom_range(0, 3) == 0) ? $urandom_range(1, 12) : 0;
				end
			end
		endcase
	end

	// Watchdog on cycles with no item moving on either side
	initial begin
		wait (arst_n);
		while (quiet_cycles < QUIET_LIMIT) begin
			@(posedge clk);
		end
		$display("Regression FAIL");
		$finish;
	end

	// Send one byte; bursts of random length separated by random gaps
	task automatic send_code(input logic [7:0] code);
		int unsigned gap;
		if (burst_left == 0) begin
			gap        = $urandom_range(1, 8);
			burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
				: $urandom_range(1, 20);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		burst_left--;
		in_valid <= 1'b1;
		scancode <= code;
		do @(posedge clk); while (!in_ready);
	endtask

	// Mostly keys that carry characters, sometimes any key code
	function automatic logic [6:0] pick_key();
		if ($urandom_range(0, 4) == 0) begin
			return 7'($urandom_range(0, 127));
		end
		return 7'($urandom_range(1, 8'h39));
	endfunction

	// One typing action: key strokes, modifier changes, caps, prefixed keys, noise
	task automatic type_action();
		int unsigned sel;
		logic [6:0]  key;
		sel = $urandom_range(0, 99);
		if (sel < 45) begin
			key = pick_key();
			send_code({1'b0, key});
			if ($urandom_range(0, 3) != 0) begin
				send_code({1'b0, key} | RELEASE_BIT);
			end
		end else if (sel < 57) begin
			case ($urandom_range(0, 3))
				0: key = KEY_LSHIFT;
				1: key = KEY_RSHIFT;
				2: key = KEY_CTRL;
				default: key = KEY_ALT;
			endcase
			if ($urandom_range(0, 3) == 0) begin
				send_code(SC_PREFIX);
			end
			send_code($urandom_range(0, 1) ? {1'b0, key} : ({1'b0, key} | RELEASE_BIT));
		end else if (sel < 62) begin
			send_code(SC_CAPS);
			if ($urandom_range(0, 1)) begin
				send_code(SC_CAPS | RELEASE_BIT);
			end
		end else if (sel < 72) begin
			send_code(SC_PREFIX);
			key = pick_key();
			send_code($urandom_range(0, 1) ? {1'b0, key} : ({1'b0, key} | RELEASE_BIT));
		end else if (sel < 78) begin
			send_code({1'b0, KEY_CTRL});
			if ($urandom_range(0, 2) == 0) begin
				send_code({1'b0, KEY_LSHIFT});
			end
			send_code($urandom_range(0, 1) ? 8'h20 : 8'h2E);
			send_code({1'b0, KEY_CTRL} | RELEASE_BIT);
			send_code({1'b0, KEY_LSHIFT} | RELEASE_BIT);
		end else begin
			send_code(8'($urandom_range(0, 255)));
		end
	endtask

	// Main sequence
	initial begin
		logic [7:0] directed_codes [] = '{
			8'h1E,          // plain letter
			8'h00,          // key without character
			8'h2A, 8'h1E,   // shift held: capital
			8'h02,          // shifted digit
			8'h1D, 8'h20,   // ctrl with shift: D stays a character
			8'hAA, 8'h20,   // ctrl d: end of file
			8'h2E, 8'h9D,   // ctrl c: interrupt, then ctrl up
			8'h3A,          // caps lock on
			8'hBA,          // caps release only clears the prefix
			8'hE0, 8'h36,   // prefixed shift code is a plain key, prefix stays
			8'h15,          // prefixed make keeps prefix armed
			8'h1D, 8'h2E,   // prefixed ctrl still counts
			8'hE0, 8'h9D,
			8'h38, 8'h1E,   // alt does not change the character
			8'hB8,
			8'h3A,          // caps lock off
			8'h4E,          // keypad plus
			8'hFF           // highest release code
		};

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_codes[i]) begin
			send_code(directed_codes[i]);
		end

		while (accepted_items < TARGET_ITEMS) begin
			type_action();
		end
		in_valid <= 1'b0;

		// Drain outstanding results, then watch for stray ones
		while (sb.pending() != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (sb.mismatches == 0 && sb.pending() == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule

FILE: files.f
hw/rtl/sc2a_pkg.sv
hw/rtl/sc2a_decode.sv
hw/rtl/scancode_to_ascii_translator.sv
hw/rtl/sc2a_checker.sv
tb/sv/tb_scancode_to_ascii_translator.sv
